@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers; clock is clk, reset is rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mcma_pkg.sv @@
`default_nettype none

package mcma_pkg;

  localparam int CHANNELS    = 8;
  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 10;

  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W       = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int STORE_DEPTH = CHANNELS * WINDOW;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ACC_W       = SAMPLE_BITS + $clog2(WINDOW);

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int COUNT_W     = 16;
  localparam int AVG_W       = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_AVG_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_SHIFT     = 1'd1;

  localparam logic [COUNT_W-1:0] MIN_AVG_COUNT_RESET = 16'd24;
  localparam logic [2:0]         AVG_SHIFT_RESET     = 3'd4;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [CH_W-1:0] ch,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(ADDR_W'(ch) * ADDR_W'(WINDOW) + ADDR_W'(idx));
  endfunction

endpackage

`default_nettype wire

@@ rtl/multichannel_moving_average_top.sv @@
// An accepted beat goes from S_IDLE to S_DONE, where the result is registered onto
//   the output; when an average is formed, S_SUM first sums the channel ring.
// One item at a time: no new input beat is taken until its result is registered;
//   the sum reads the sample store one entry per cycle through its single read port.
// Reset: synchronous; afterwards the sample store is cleared one entry per cycle,
//   all CHANNELS * WINDOW entries (128), with no input beat taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module multichannel_moving_average_top
  import mcma_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             channel,
  input  wire logic [9:0]             sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  channel_out,
  output logic [AVG_W-1:0]            average,
  output logic                        updated,
  output logic                        discarded
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SUM, S_DONE} state_t;

  state_t                 state;
  logic [ADDR_W-1:0]      clr_addr;
  logic [COUNT_W-1:0]     min_avg_count;
  logic [2:0]             avg_shift;
  logic [COUNT_W-1:0]     conv_count;
  logic [IDX_W-1:0]       wr_ptr [CHANNELS];
  logic [AVG_W-1:0]       chan_avg [CHANNELS];

  logic [2:0]             item_channel;
  logic [CH_W-1:0]        item_ch;
  logic                   item_valid;
  logic                   item_warm;
  logic                   item_upd;
  logic [CNT_W-1:0]       issue_cnt;
  logic                   rd_pending;
  logic [ACC_W-1:0]       acc;

  logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata;

  logic                   accept;
  logic [CH_W-1:0]        in_ch;
  logic                   in_chan_ok;
  logic                   in_warm;
  logic                   in_store;
  logic                   in_avg;
  logic                   issue;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [IDX_W-1:0]       wr_ptr_next;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_ch      = CH_W'(channel);
  assign in_chan_ok = (32'(channel) < 32'(CHANNELS));
  assign in_warm    = (32'(conv_count) < 32'(CHANNELS));
  assign in_store   = in_chan_ok && !in_warm;
  assign in_avg     = in_store && (conv_count >= min_avg_count);
  assign issue      = (state == S_SUM) && (32'(issue_cnt) < 32'(WINDOW));

  assign wr_ptr_next = (32'(wr_ptr[in_ch]) == WINDOW - 1) ? '0 : wr_ptr[in_ch] + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && in_store) begin
      mem_we    = 1'b1;
      mem_waddr = store_addr(in_ch, wr_ptr[in_ch]);
      mem_wdata = SAMPLE_BITS'(sample);
    end
  end

  assign mem_raddr = store_addr(item_ch, IDX_W'(issue_cnt));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rdata <= store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_avg_count <= MIN_AVG_COUNT_RESET;
      avg_shift     <= AVG_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_AVG_COUNT: min_avg_count <= cfg_data;
        REG_AVG_SHIFT:     avg_shift     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      conv_count <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wr_ptr[i]   <= '0;
        chan_avg[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == STORE_DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_channel <= channel;
            item_ch      <= in_ch;
            item_valid   <= in_chan_ok;
            item_warm    <= in_warm;
            item_upd     <= in_avg;
            issue_cnt    <= '0;
            rd_pending   <= 1'b0;
            acc          <= '0;
            if (conv_count != COUNT_MAX) begin
              conv_count <= conv_count + 1'b1;
            end
            if (in_store) begin
              wr_ptr[in_ch] <= wr_ptr_next;
            end
            state <= in_avg ? S_SUM : S_DONE;
          end
        end
        S_SUM: begin
          rd_pending <= issue;
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_pending) begin
            acc <= acc + ACC_W'(rdata);
          end
          if (!issue && !rd_pending) begin
            chan_avg[item_ch] <= AVG_W'(acc >> avg_shift);
            state             <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            channel_out <= item_channel;
            average     <= item_valid ? chan_avg[item_ch] : '0;
            updated     <= item_upd;
            discarded   <= item_warm;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK_ALWAYS(a_no_accept_in_clear, (state == S_CLEAR) |-> !in_ready, "beat taken during store clear")
  `ASSERT_CLK(a_one_item_at_a_time, accept |=> !in_ready, "second beat taken before result")
  `ASSERT_CLK(a_upd_not_warm, out_valid |-> !(updated && discarded), "update flagged on warm-up beat")
  `ASSERT_CLK(a_issue_bound, (state == S_SUM) |-> (32'(issue_cnt) <= WINDOW), "read index past window")
  `ASSERT_CLK(a_count_saturates, (conv_count == COUNT_MAX) |=> (conv_count == COUNT_MAX), "count wrapped")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top
  import mcma_pkg::*;
;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int IDLE_PCT    = 9;
  localparam int DRAIN_WAIT  = 25;
  localparam int PHASE_BEATS = 65;

  typedef struct packed {
    logic [2:0]       ch;
    logic [AVG_W-1:0] avg;
    logic             upd;
    logic             disc;
  } avg_result_t;

  typedef struct {
    int ch;
    int smp;
    bit typed;
    int avg;
    int upd;
    int disc;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_AVG_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           channel = '0;
  logic [9:0]           sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           channel_out;
  logic [AVG_W-1:0]     average;
  logic                 updated;
  logic                 discarded;

  multichannel_moving_average_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .channel     (channel),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel_out (channel_out),
    .average     (average),
    .updated     (updated),
    .discarded   (discarded)
  );

  always #4 clk = ~clk;

  // filter state mirror
  logic [SAMPLE_BITS-1:0] ring [CHANNELS][WINDOW];
  logic [IDX_W-1:0]       ring_wp [CHANNELS];
  logic [AVG_W-1:0]       ch_avg [CHANNELS];
  logic [COUNT_W-1:0]     conv_count = '0;
  logic [COUNT_W-1:0]     avg_threshold = MIN_AVG_COUNT_RESET;
  logic [2:0]             sum_shift = AVG_SHIFT_RESET;

  avg_result_t pending_avgs [$];
  avg_result_t want;
  plan_row_t   plan [22];

  bit quiet = 1'b0;
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_updates = 0;
  int n_drops = 0;
  int n_settings = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      ring_wp[c] = '0;
      ch_avg[c] = '0;
      for (int i = 0; i < WINDOW; i++) ring[c][i] = '0;
    end
  end

  function automatic avg_result_t filter_step(input logic [2:0] ch,
                                              input logic [9:0] smp);
    avg_result_t r;
    int unsigned sum;
    bit in_range;
    bit warm;
    in_range = int'(ch) < CHANNELS;
    warm = conv_count < COUNT_W'(CHANNELS);
    r.ch = ch;
    r.avg = '0;
    r.upd = 1'b0;
    r.disc = warm;
    if (!warm && in_range) begin
      ring[ch][ring_wp[ch]] = smp[SAMPLE_BITS-1:0];
      if (conv_count >= avg_threshold) begin
        sum = 0;
        for (int i = 0; i < WINDOW; i++) sum += ring[ch][i];
        ch_avg[ch] = AVG_W'(sum >> sum_shift);
        r.upd = 1'b1;
      end
      ring_wp[ch] = (int'(ring_wp[ch]) == WINDOW - 1) ? '0 : ring_wp[ch] + 1'b1;
    end
    if (in_range) r.avg = ch_avg[ch];
    if (conv_count != COUNT_MAX) conv_count++;
    return r;
  endfunction

  function automatic logic [9:0] pick_sample();
    case ($urandom_range(9))
      0: return 10'h000;
      1: return 10'h3FF;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (errors < 30) $display("mismatch %s: got %0d, expected %0d", what, got, exp_val);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_AVG_COUNT) avg_threshold = val;
    else sum_shift = val[2:0];
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [COUNT_W-1:0] thresh, input logic [2:0] shift);
    write_reg(REG_MIN_AVG_COUNT, thresh);
    write_reg(REG_AVG_SHIFT, COUNT_W'(shift));
    n_settings++;
  endtask

  task automatic send_sample(input logic [2:0] ch, input logic [9:0] smp,
                             input bit typed, input avg_result_t typed_res);
    avg_result_t pred;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
    pred = filter_step(ch, smp);
    pending_avgs.push_back(typed ? typed_res : pred);
    n_sent++;
  endtask

  task automatic send_random();
    send_sample(3'($urandom_range(7)), pick_sample(), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_avgs.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_avgs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_avgs.size() == 0) begin
          report_mismatch("beat with nothing pending, channel", channel_out, -1);
        end else begin
          want = pending_avgs.pop_front();
          n_checked++;
          if (updated) n_updates++;
          if (discarded) n_drops++;
          if (channel_out !== want.ch) report_mismatch("channel_out", channel_out, want.ch);
          if (average !== want.avg) report_mismatch("average", average, want.avg);
          if (updated !== want.upd) report_mismatch("updated", updated, want.upd);
          if (discarded !== want.disc) report_mismatch("discarded", discarded, want.disc);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    avg_result_t typed_res;
    plan = '{
      '{0, 10'h000, 1, 0, 0, 1}, '{1, 10'h3FF, 1, 0, 0, 1}, '{2, 10'h155, 1, 0, 0, 1},
      '{3, 10'h2AA, 1, 0, 0, 1}, '{4, 10'h001, 1, 0, 0, 1}, '{5, 10'h200, 1, 0, 0, 1},
      '{6, 10'h3FE, 1, 0, 0, 1}, '{7, 10'h000, 1, 0, 0, 1},
      '{0, 10'h3FF, 1, 15, 1, 0}, '{0, 10'h3FF, 1, 31, 1, 0}, '{1, 10'h000, 1, 0, 1, 0},
      '{7, 10'h3FF, 0, 0, 0, 0}, '{7, 10'h3FF, 0, 0, 0, 0}, '{7, 10'h3FF, 0, 0, 0, 0},
      '{7, 10'h3FF, 0, 0, 0, 0}, '{3, 10'h2AA, 0, 0, 0, 0}, '{4, 10'h155, 0, 0, 0, 0},
      '{5, 10'h3FF, 0, 0, 0, 0}, '{6, 10'h000, 0, 0, 0, 0}, '{2, 10'h3FF, 0, 0, 0, 0},
      '{0, 10'h000, 0, 0, 0, 0}, '{0, 10'h3FF, 0, 0, 0, 0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // threshold below warm-up, shift of 6
    set_filter('0, 3'd6);
    foreach (plan[i]) begin
      typed_res.ch = 3'(plan[i].ch);
      typed_res.avg = AVG_W'(plan[i].avg);
      typed_res.upd = plan[i].upd[0];
      typed_res.disc = plan[i].disc[0];
      send_sample(3'(plan[i].ch), 10'(plan[i].smp), plan[i].typed, typed_res);
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_filter(conv_count + 16'd40, 3'd0);
        1: set_filter('0, 3'd7);
        2: set_filter(COUNT_MAX, 3'd3);
        3: set_filter(conv_count + 16'd20, 3'd5);
        4: set_filter(16'($urandom_range(int'(conv_count) + 60)), 3'd1);
        default: set_filter('0, 3'd2);
      endcase
      quiet = (p == 1);
      repeat (PHASE_BEATS) send_random();
      drain();
    end

    quiet = 1'b0;
    set_filter(16'd40000, 3'd6);
    repeat (40) send_random();
    drain();

    $display("%0d samples sent, %0d results checked: %0d averages recomputed, %0d warm-up drops",
             n_sent, n_checked, n_updates, n_drops);
    $display("%0d filter settings used, conversion count ended at %0d", n_settings,
             conv_count);
    if (errors == 0 && pending_avgs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
